>>> sv/imu_dfr_pkg.sv
// Shared constants and types for the inertial sensor frame deframer.
// Used by imu_frame_deframer; depends on nothing else.
package imu_dfr_pkg;

	localparam logic [7:0] HDR_B0 = 8'hBD;
	localparam logic [7:0] HDR_B1 = 8'hDB;
	localparam logic [7:0] HDR_B2 = 8'h04;

	localparam int OFF_W       = 5;
	localparam int NUM_WORDS   = 9;
	localparam int SLOT_W      = 4;
	localparam int ANGLE_W     = 22;
	localparam int RATE_W      = 23;
	localparam int ACCEL_W     = 16;
	localparam int OUT_BITS    = 3 * ANGLE_W + 3 * RATE_W + 3 * ACCEL_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [OFF_W-1:0] FIRST_BODY_OFF = 5'd3;
	localparam logic [OFF_W-1:0] LAST_OFF       = 5'd31;

	localparam logic signed [ANGLE_W-1:0] ANGLE_MUL = 22'sd45;
	localparam logic signed [RATE_W-1:0]  RATE_MUL  = 23'sd75;

	typedef logic [15:0] word_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] idx;
	} slot_t;

	// Map a high-byte offset to its word slot.
	function automatic slot_t slot_of(input logic [OFF_W-1:0] o);
		slot_t s;
		s.hit = 1'b0;
		s.idx = '0;
		if (o inside {5'd4, 5'd6, 5'd8}) begin
			s.hit = 1'b1;
			s.idx = SLOT_W'((o - 5'd4) >> 1);
		end else if (o inside {5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24}) begin
			s.hit = 1'b1;
			s.idx = SLOT_W'(((o - 5'd14) >> 1) + 5'd3);
		end
		return s;
	endfunction

endpackage

>>> sv/imu_frame_deframer.sv
// Top level of the inertial sensor frame deframer: header hunt, frame
// capture and fixed-point scaling. Depends on imu_dfr_pkg.

// Takes one byte per word on s_axis and hunts for the header BD DB 04; a BD
// byte that breaks the match restarts the hunt as a first header byte. After
// the header the remaining 29 bytes of the 32-byte frame are counted out,
// with nine little-endian signed 16-bit words taken from offsets 3-8 and
// 13-24. The frame's last byte yields one m_axis word with the three angles
// (raw*45, 1/4096 degree), three rates (raw*75, 1/16384) and three
// accelerations (raw, 1/16384 g). Header bytes inside a frame body are data.
// One byte is taken every clock while the consumer does not stall: a byte
// goes through the input register and then a single pass of state update
// and scaling into the output register, which that pass may enter only when
// it is free or being read; the frame's result is presented from there.
// A stalled consumer holds the output register and lets one more byte wait
// in the input register before s_axis_tready drops.
module imu_frame_deframer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // rx_byte
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// roll_q, pitch_q, yaw_q, rate_x_q, rate_y_q, rate_z_q,
	// accel_x_q, accel_y_q, accel_z_q, one zero pad bit
	output logic [imu_dfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          advance;

	logic [1:0]                    hdr_progress_q;
	logic                          in_frame_q;
	logic [imu_dfr_pkg::OFF_W-1:0] offset_q;
	logic [7:0]                    low_byte_q;
	imu_dfr_pkg::word_t            words_q [imu_dfr_pkg::NUM_WORDS];

	logic                          out_valid_q;
	logic [imu_dfr_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [7:0]                    expect_byte;
	logic                          frame_done;
	imu_dfr_pkg::slot_t            slot;

	logic signed [imu_dfr_pkg::ANGLE_W-1:0] angle [3];
	logic signed [imu_dfr_pkg::RATE_W-1:0]  rate  [3];
	logic signed [imu_dfr_pkg::ACCEL_W-1:0] accel [3];
	logic [imu_dfr_pkg::OUT_TDATA_W-1:0]   packed_out;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		case (hdr_progress_q)
			2'd0:    expect_byte = imu_dfr_pkg::HDR_B0;
			2'd1:    expect_byte = imu_dfr_pkg::HDR_B1;
			default: expect_byte = imu_dfr_pkg::HDR_B2;
		endcase
	end

	assign slot       = imu_dfr_pkg::slot_of(offset_q);
	assign frame_done = in_frame_q && (offset_q == imu_dfr_pkg::LAST_OFF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_progress_q <= 2'd0;
			in_frame_q     <= 1'b0;
			offset_q       <= '0;
		end else if (advance) begin
			if (!in_frame_q) begin
				if (byte_s1 == expect_byte) begin
					if (hdr_progress_q == 2'd2) begin
						hdr_progress_q <= 2'd0;
						in_frame_q     <= 1'b1;
						offset_q       <= imu_dfr_pkg::FIRST_BODY_OFF;
					end else begin
						hdr_progress_q <= hdr_progress_q + 2'd1;
					end
				end else begin
					hdr_progress_q <= (byte_s1 == imu_dfr_pkg::HDR_B0) ? 2'd1 : 2'd0;
				end
			end else if (frame_done) begin
				in_frame_q     <= 1'b0;
				offset_q       <= '0;
				hdr_progress_q <= 2'd0;
			end else begin
				offset_q <= offset_q + imu_dfr_pkg::OFF_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_frame_q) begin
			if (offset_q[0]) begin
				low_byte_q <= byte_s1;
			end else if (slot.hit) begin
				words_q[slot.idx] <= {byte_s1, low_byte_q};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			angle[k] = imu_dfr_pkg::ANGLE_W'($signed(words_q[k])) * imu_dfr_pkg::ANGLE_MUL;
			rate[k]  = imu_dfr_pkg::RATE_W'($signed(words_q[3 + k])) * imu_dfr_pkg::RATE_MUL;
			accel[k] = $signed(words_q[6 + k]);
		end
		packed_out = {{(imu_dfr_pkg::OUT_TDATA_W - imu_dfr_pkg::OUT_BITS){1'b0}},
			accel[2], accel[1], accel[0],
			rate[2], rate[1], rate[0],
			angle[2], angle[1], angle[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= frame_done;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_done) begin
			out_data_q <= packed_out;
		end
	end

endmodule
